// ===== hw/rtl/kptm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_pkg
// shared types, constants and helpers of the keyword prefix trie matcher
// ----------------------------------------------------------------------------
package kptm_pkg;

	localparam int TABLE_DEPTH    = 1024;
	localparam int IDX_W          = $clog2(TABLE_DEPTH);
	localparam int MAX_WALK_STEPS = 256;
	localparam int STEP_W         = $clog2(MAX_WALK_STEPS + 1);

	// table entry flag positions
	localparam int SIB_BIT = 7;
	localparam int MIN_BIT = 8;
	localparam int NEG_BIT = 15;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// feed modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_CHAR  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [9:0]         table_addr;
		logic signed [15:0] table_word;
		logic [7:0]         character;
		logic               word_start;
	} feed_t;

	typedef struct packed {
		logic        found;
		logic [15:0] keyword_id;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic wr;
		logic load_char;
		logic set_start;
		logic clr_steps;
		logic rd_entry;
		logic rd_next;
		logic ld_next;
		logic step_sib;
		logic res_set;
		logic res_hit;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic feed_letter;
		logic letter;
		logic neg;
		logic char_match;
		logic sib;
		logic minimal;
		logic cap;
		logic out_free;
	} dp_stat_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
	endfunction

endpackage

// ===== hw/rtl/kptm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_dp
// datapath: trie table memory, walk index, step counter and result register
// ----------------------------------------------------------------------------
module kptm_dp import kptm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  feed_t    feed,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  logic     result_stall,
	output logic     result_valid,
	output result_t  result
);

	logic [15:0]       mem [TABLE_DEPTH];
	logic [15:0]       rdata_q;
	logic [7:0]        char_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] steps_q;
	logic              res_found_q;
	logic [15:0]       res_id_q;
	result_t           out_q;
	logic              out_valid_q;

	logic [7:0]       feed_char;
	logic [5:0]       start_idx;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;

	assign feed_char = fold_char(feed.character);
	// letters a..z start at pair (c - 'a')
	assign start_idx = {5'(feed_char - CHAR_LOWER_A), 1'b0};
	assign wr_addr   = IDX_W'(feed.table_addr);
	assign rd_addr   = cmd.rd_next ? idx_q + IDX_W'(1) : idx_q;

	// table memory, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= feed.table_word;
		end
		if (cmd.rd_entry || cmd.rd_next) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			char_q <= feed_char;
		end
		if (cmd.res_set) begin
			res_found_q <= cmd.res_hit;
			res_id_q    <= cmd.res_hit ? 16'(16'd0 - rdata_q) : 16'd0;
		end
		if (cmd.emit) begin
			out_q <= '{found: res_found_q, keyword_id: res_id_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_start) begin
				idx_q <= IDX_W'(start_idx);
			end else if (cmd.step_sib) begin
				idx_q <= idx_q + IDX_W'(2);
			end else if (cmd.ld_next) begin
				idx_q <= IDX_W'(rdata_q);
			end
			if (cmd.clr_steps) begin
				steps_q <= '0;
			end else if (cmd.rd_entry) begin
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.feed_letter = is_letter(feed_char);
	assign stat.letter      = is_letter(char_q);
	assign stat.neg         = rdata_q[NEG_BIT];
	assign stat.char_match  = (char_q == {1'b0, rdata_q[6:0]});
	assign stat.sib         = rdata_q[SIB_BIT];
	assign stat.minimal     = rdata_q[MIN_BIT];
	assign stat.cap         = (steps_q == STEP_W'(MAX_WALK_STEPS));
	assign stat.out_free    = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== hw/rtl/kptm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_ctrl
// controller: table writes, per-character table reads and the result hand-off
// ----------------------------------------------------------------------------
module kptm_ctrl import kptm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     feed_valid,
	input  logic     feed_mode,
	input  logic     feed_word_start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     feed_stall
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ENTRY,
		ST_EVAL,
		ST_RD_NEXT,
		ST_LD_NEXT,
		ST_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   walk_q, walk_d;      // a word is being walked
	logic   cons_q, cons_d;      // character consumed once next index loads

	always_comb begin
		state_d = state_q;
		walk_d  = walk_q;
		cons_d  = cons_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (feed_valid) begin
					if (feed_mode == MODE_WRITE) begin
						cmd.wr = 1'b1;
					end else if (feed_word_start) begin
						cmd.clr_steps = 1'b1;
						if (stat.feed_letter) begin
							cmd.load_char = 1'b1;
							cmd.set_start = 1'b1;
							walk_d        = 1'b1;
							state_d       = ST_RD_ENTRY;
						end else begin
							cmd.res_set = 1'b1;
							state_d     = ST_EMIT;
						end
					end else if (walk_q) begin
						cmd.clr_steps = 1'b1;
						cmd.load_char = 1'b1;
						state_d       = ST_RD_ENTRY;
					end
				end
			end
			ST_RD_ENTRY: begin
				if (stat.cap) begin
					cmd.res_set = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.rd_entry = 1'b1;
					state_d      = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.neg) begin
					cmd.res_set = 1'b1;
					cmd.res_hit = !stat.letter;
					state_d     = ST_EMIT;
				end else if (stat.char_match) begin
					cons_d  = 1'b1;
					state_d = ST_RD_NEXT;
				end else if (stat.sib) begin
					cmd.step_sib = 1'b1;
					state_d      = ST_RD_ENTRY;
				end else if (stat.minimal && !stat.letter) begin
					cons_d  = 1'b0;
					state_d = ST_RD_NEXT;
				end else begin
					cmd.res_set = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_RD_NEXT: begin
				cmd.rd_next = 1'b1;
				state_d     = ST_LD_NEXT;
			end
			ST_LD_NEXT: begin
				cmd.ld_next = 1'b1;
				state_d     = cons_q ? ST_IDLE : ST_RD_ENTRY;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					walk_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q  <= 1'b0;
			cons_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
			cons_q  <= cons_d;
		end
	end

	assign feed_stall = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/keyword_prefix_trie_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_prefix_trie_matcher
// matches keywords or unambiguous abbreviations against a packed trie table
// ----------------------------------------------------------------------------
// Each feed item either writes one 16-bit table word (mode 0) or supplies one
// character of a word (mode 1, word_start on the first one). A table write
// is taken in the idle state and leaves the controller idle. A character is
// accepted, then each table entry examined costs one read of the single-port
// table and one evaluate, and each next index that is followed costs one read
// and one load of the walk index. A decided word then passes through an emit
// state that loads the output register, and waits there while an earlier
// result is still held and result_stall is high. Characters after a decision
// are dropped until the next word_start. Each character may spend at most
// MAX_WALK_STEPS table entry reads before the word is reported as not found.
// The table has no reset; reading an unwritten entry gives undefined data.
// ----------------------------------------------------------------------------
module keyword_prefix_trie_matcher import kptm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    feed_valid,
	output logic    feed_stall,
	input  feed_t   feed,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: accepts items only when idle, steps the table walk
	kptm_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.feed_valid      (feed_valid),
		.feed_mode       (feed.mode),
		.feed_word_start (feed.word_start),
		.stat            (stat),
		.cmd             (cmd),
		.feed_stall      (feed_stall)
	);

	// table memory, walk registers and result register
	kptm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed         (feed),
		.cmd          (cmd),
		.stat         (stat),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	// a miss never carries a keyword id
	a_miss_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.keyword_id == 16'd0)
		else $error("not-found item with nonzero keyword id");

	// a table write leaves the controller idle
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && !feed_stall && (feed.mode == MODE_WRITE) |=> !feed_stall)
		else $error("table write did not return to idle");

	// a word starting with a non-letter goes straight to the result stage
	a_bad_start: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && !feed_stall && (feed.mode == MODE_CHAR) && feed.word_start
		&& !is_letter(fold_char(feed.character)) |=> feed_stall)
		else $error("non-letter word start not decided");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyword prefix trie matcher
// ----------------------------------------------------------------------------
// The whole table is cleared first so that no walk can land on an entry that
// was never written. A short table of directed items then builds a tiny trie
// by hand and walks it through the corner cases: case folding, sibling and
// minimal-prefix entries, the most negative result code, a non-letter first
// character, a restart in mid-word, characters after a decision and a cyclic
// table that runs into the walk cap. The random part loads a fresh trie of a
// few random keywords per round and feeds whole keywords, abbreviations,
// misspellings, unterminated words and noise. A local trie walker predicts
// each random result; all results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import kptm_pkg::*;

	localparam int RAND_ITEMS   = 500;
	localparam int IDLE_PCT     = 14;
	localparam int STUCK_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 4 * MAX_WALK_STEPS + 500;
	localparam int MAX_NODES    = 32;
	localparam int MAX_KW       = 5;
	localparam int MAX_KW_LEN   = 5;

	typedef enum logic [1:0] {WS_IDLE, WS_WALK, WS_DONE} word_state_t;

	// one row of the directed table; typed rows carry their expected result
	typedef struct {
		feed_t   item;
		bit      typed;
		result_t res;
	} drow_t;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    feed_valid   = 1'b0;
	logic    feed_stall;
	feed_t   feed         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// shadow of the trie and of the word being matched
	logic [15:0]      trie_mem [TABLE_DEPTH];
	logic [IDX_W-1:0] walk_idx   = '0;
	word_state_t      word_state = WS_IDLE;
	result_t          expected_results [$];
	result_t          oldest;

	// trie under construction for the current random round
	int          nd_ch   [MAX_NODES];
	int          nd_kid  [MAX_NODES];
	int          nd_sib  [MAX_NODES];
	int          nd_code [MAX_NODES];
	int          nd_list [MAX_NODES];
	int          nd_count;
	logic [7:0]  kw_txt  [MAX_KW][8];
	int          kw_len  [MAX_KW];
	int          kw_num;

	drow_t directed [$];
	bit    quiet       = 1'b0;
	int    n_items     = 0;
	int    n_words     = 0;
	int    n_results   = 0;
	int    n_hits      = 0;
	int    n_tables    = 0;
	int    n_errors    = 0;
	int    idle_cycles = 0;
	int    rand_start;

	keyword_prefix_trie_matcher i_dut (
		.clk,
		.arst_n,
		.feed_valid,
		.feed_stall,
		.feed,
		.result_valid,
		.result_stall,
		.result
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------------
	// item builders, unused fields get random values
	// ------------------------------------------------------------------------
	function automatic feed_t write_item(input int a, input logic [15:0] w);
		feed_t f;
		f.mode       = MODE_WRITE;
		f.table_addr = 10'(a);
		f.table_word = w;
		f.character  = 8'($urandom);
		f.word_start = 1'($urandom);
		return f;
	endfunction

	function automatic feed_t char_item(input logic [7:0] c, input logic s);
		feed_t f;
		f.mode       = MODE_CHAR;
		f.table_addr = 10'($urandom);
		f.table_word = 16'($urandom);
		f.character  = c;
		f.word_start = s;
		return f;
	endfunction

	function automatic drow_t row_w(input int a, input logic [15:0] w);
		drow_t r;
		r.item  = write_item(a, w);
		r.typed = 1'b0;
		r.res   = '0;
		return r;
	endfunction

	function automatic drow_t row_c(input logic [7:0] c, input logic s);
		drow_t r;
		r.item  = char_item(c, s);
		r.typed = 1'b0;
		r.res   = '0;
		return r;
	endfunction

	function automatic drow_t row_r(input logic [7:0] c, input logic s, input logic hit,
			input logic [15:0] id);
		drow_t r;
		r.item           = char_item(c, s);
		r.typed          = 1'b1;
		r.res.found      = hit;
		r.res.keyword_id = id;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// trie walker
	// ------------------------------------------------------------------------
	function automatic bit lower_letter(input logic [7:0] c);
		return c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z;
	endfunction

	// pointer half of the pair at index i, wrapped to the table depth
	function automatic logic [IDX_W-1:0] pair_next(input logic [IDX_W-1:0] i);
		return trie_mem[IDX_W'(i + 1)][IDX_W-1:0];
	endfunction

	// walks the table for one character; made is set once the word is decided
	function automatic void walk_char(input logic [7:0] c, output bit made, output result_t r);
		logic [15:0] e;
		made = 1'b0;
		r    = '0;
		for (int n = 0; n < MAX_WALK_STEPS; n++) begin
			e = trie_mem[walk_idx];
			if (e[NEG_BIT]) begin
				// end of keyword, a hit only when the word ends here too
				made = 1'b1;
				if (!lower_letter(c)) begin
					r.found      = 1'b1;
					r.keyword_id = -e;
				end
				return;
			end
			if (c == {1'b0, e[6:0]}) begin
				walk_idx = pair_next(walk_idx);
				return;
			end
			if (e[SIB_BIT]) begin
				walk_idx = IDX_W'(walk_idx + 2);
			end else if (e[MIN_BIT] && !lower_letter(c)) begin
				// abbreviation long enough, follow on with the same character
				walk_idx = pair_next(walk_idx);
			end else begin
				made = 1'b1;
				return;
			end
		end
		// runaway walk
		made = 1'b1;
	endfunction

	function automatic void predict_feed(input feed_t f, output bit made, output result_t r);
		logic [7:0] c;
		made = 1'b0;
		r    = '0;
		if (f.mode == MODE_WRITE) begin
			trie_mem[f.table_addr] = f.table_word;
			return;
		end
		c = f.character;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			c = c + CASE_OFFSET;
		end
		if (f.word_start) begin
			if (!lower_letter(c)) begin
				made       = 1'b1;
				word_state = WS_DONE;
				return;
			end
			// each first letter owns a fixed root pair
			walk_idx   = IDX_W'({8'(c - CHAR_LOWER_A), 1'b0});
			word_state = WS_WALK;
		end else if (word_state != WS_WALK) begin
			return;
		end
		walk_char(c, made, r);
		if (made) begin
			word_state = WS_DONE;
		end
	endfunction

	// ------------------------------------------------------------------------
	// feed side driver, idles at random unless in the quiet stretch
	// ------------------------------------------------------------------------
	task automatic send_item(input feed_t it, input bit typed = 1'b0, input result_t res = '0);
		bit      made;
		result_t r;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			feed_valid <= 1'b0;
			@(posedge clk);
		end
		feed_valid <= 1'b1;
		feed       <= it;
		@(posedge clk);
		while (feed_stall) begin
			@(posedge clk);
		end
		predict_feed(it, made, r);
		if (typed) begin
			expected_results.push_back(res);
		end else if (made) begin
			expected_results.push_back(r);
		end
		n_items++;
		if (it.mode == MODE_CHAR && it.word_start) begin
			n_words++;
		end
	endtask

	// ------------------------------------------------------------------------
	// random trie rounds
	// ------------------------------------------------------------------------
	function automatic int list_len(input int n);
		int len;
		len = (nd_code[n] != 0) ? 1 : 0;
		for (int k = nd_kid[n]; k >= 0; k = nd_sib[k]) begin
			len++;
		end
		return len;
	endfunction

	// next-index word with random bits above the index
	function automatic logic [15:0] next_word(input int a);
		return {6'($urandom), 10'(a)};
	endfunction

	function automatic void add_keyword(input int w, input int code);
		int n, k, prev;
		n = 0;
		for (int i = 0; i < kw_len[w]; i++) begin
			k    = nd_kid[n];
			prev = -1;
			while (k >= 0 && nd_ch[k] != kw_txt[w][i]) begin
				prev = k;
				k    = nd_sib[k];
			end
			if (k < 0) begin
				k          = nd_count++;
				nd_ch[k]   = kw_txt[w][i];
				nd_kid[k]  = -1;
				nd_sib[k]  = -1;
				nd_code[k] = 0;
				if (prev < 0) nd_kid[n] = k;
				else nd_sib[prev] = k;
			end
			n = k;
		end
		nd_code[n] = code;
	endfunction

	// lays the trie out as sibling lists, breadth first, at a random base
	task automatic load_trie();
		int          q [$];
		int          n, idx, len, pos, free_ptr;
		logic [15:0] e;
		free_ptr = 2 * $urandom_range(26, 440);
		for (int k = nd_kid[0]; k >= 0; k = nd_sib[k]) begin
			nd_list[k] = free_ptr;
			free_ptr  += 2 * list_len(k);
			q.push_back(k);
			e = {1'b0, 6'($urandom), 2'($urandom), 7'(nd_ch[k])};
			send_item(write_item(2 * (nd_ch[k] - CHAR_LOWER_A), e));
			send_item(write_item(2 * (nd_ch[k] - CHAR_LOWER_A) + 1, next_word(nd_list[k])));
		end
		while (q.size() > 0) begin
			n   = q.pop_front();
			idx = nd_list[n];
			len = list_len(n);
			pos = 0;
			for (int k = nd_kid[n]; k >= 0; k = nd_sib[k]) begin
				nd_list[k] = free_ptr;
				free_ptr  += 2 * list_len(k);
				q.push_back(k);
				// sibling flag on all but the last entry, minimal prefix at random on lone ones
				e = {1'b0, 6'($urandom), (len == 1) && ($urandom_range(1) == 1),
					pos < len - 1, 7'(nd_ch[k])};
				send_item(write_item(idx, e));
				send_item(write_item(idx + 1, next_word(nd_list[k])));
				idx += 2;
				pos++;
			end
			if (nd_code[n] != 0) begin
				send_item(write_item(idx, 16'(-nd_code[n])));
				send_item(write_item(idx + 1, 16'($urandom)));
			end
		end
	endtask

	function automatic logic [7:0] term_char();
		logic [7:0] c;
		case ($urandom_range(3))
			0: c = 8'h00;
			1: c = " ";
			2: c = {1'b1, 7'($urandom)};
			default: begin
				c = 8'($urandom);
				while (lower_letter(c | CASE_OFFSET)) c = 8'($urandom);
			end
		endcase
		return c;
	endfunction

	// feeds lower-case text with random upper case, optionally terminated
	task automatic send_text(input logic [7:0] txt [8], input int n, input bit terminate);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = txt[i];
			if ($urandom_range(9) < 3) c = c - CASE_OFFSET;
			send_item(char_item(c, i == 0));
		end
		if (terminate) begin
			send_item(char_item(term_char(), 1'b0));
			// stray character after the decision
			if ($urandom_range(4) == 0) send_item(char_item(8'($urandom), 1'b0));
		end
	endtask

	task automatic run_round();
		logic [7:0] txt [8];
		int         j, n, k, code, pick;
		nd_count  = 1;
		nd_kid[0] = -1;
		kw_num    = $urandom_range(2, MAX_KW);
		for (int w = 0; w < kw_num; w++) begin
			n = 0;
			// about half the keywords share a prefix with an earlier one
			if (w > 0 && $urandom_range(1) == 1) begin
				j = $urandom_range(w - 1);
				n = $urandom_range(1, kw_len[j]);
				for (int i = 0; i < n; i++) kw_txt[w][i] = kw_txt[j][i];
			end
			k = n + $urandom_range(n == 0 ? 1 : 0, MAX_KW_LEN - n);
			for (int i = n; i < k; i++) kw_txt[w][i] = 8'(CHAR_LOWER_A + $urandom_range(25));
			kw_len[w] = k;
			case ($urandom_range(9))
				0: code = 32768;
				1: code = 1;
				default: code = $urandom_range(2, 32767);
			endcase
			add_keyword(w, code);
		end
		load_trie();
		n_tables++;
		for (int slot = $urandom_range(12, 20); slot > 0; slot--) begin
			// one stretch of the run without any idling on either side
			quiet = (n_items - rand_start >= 150) && (n_items - rand_start < 270);
			pick  = $urandom_range(99);
			k     = $urandom_range(kw_num - 1);
			for (int i = 0; i < 8; i++) txt[i] = kw_txt[k][i];
			n = kw_len[k];
			if (pick < 55) begin
				// keyword or abbreviation
				if ($urandom_range(1) == 1) n = $urandom_range(1, n);
				send_text(txt, n, 1'b1);
			end else if (pick < 70) begin
				// misspelled or overlong
				if (n < 8 && $urandom_range(1) == 1) begin
					txt[n++] = 8'(CHAR_LOWER_A + $urandom_range(25));
				end else begin
					txt[$urandom_range(n - 1)] = 8'(CHAR_LOWER_A + $urandom_range(25));
				end
				send_text(txt, n, 1'b1);
			end else if (pick < 80) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) txt[i] = 8'(CHAR_LOWER_A + $urandom_range(25));
				send_text(txt, n, 1'b1);
			end else if (pick < 88) begin
				// cut short, the next word start drops it
				send_text(txt, $urandom_range(1, n), 1'b0);
			end else if (pick < 94) begin
				send_item(write_item($urandom_range(TABLE_DEPTH - 1), 16'($urandom)));
			end else begin
				send_item(char_item(8'($urandom), 1'($urandom)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// result side: random stall, in-order check
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: result with nothing expected, found %0b id %0d",
					$time, result.found, result.keyword_id);
				n_errors++;
			end else begin
				oldest = expected_results.pop_front();
				if (result.found !== oldest.found) begin
					$display("%0t ns: found expected %0b actual %0b",
						$time, oldest.found, result.found);
					n_errors++;
				end
				if (result.keyword_id !== oldest.keyword_id) begin
					$display("%0t ns: keyword_id expected %0d actual %0d",
						$time, oldest.keyword_id, result.keyword_id);
					n_errors++;
				end
				n_results++;
				if (result.found) n_hits++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((feed_valid && !feed_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STUCK_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
				$time, idle_cycles, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		directed = '{
			row_w(12,   16'h0067),          // root g
			row_w(13,   16'hFC40),          // -> 64, junk above the index
			row_w(64,   16'h00EF),          // o, sibling follows
			row_w(65,   16'h0044),          // -> 68
			row_w(66,   16'h0165),          // e, minimal prefix
			row_w(67,   16'h0046),          // -> 70
			row_w(68,   16'h8000),          // most negative code
			row_w(70,   16'h0174),          // t, minimal prefix
			row_w(71,   16'h0048),          // -> 72
			row_w(72,   16'hFFFF),          // keyword 1, stored as -1
			row_w(50,   16'h007A),          // root z
			row_w(51,   16'h03FE),          // -> 1022
			row_w(1022, 16'h0141),          // never matches, minimal prefix
			row_w(1023, 16'hFFFE),          // -> 1022, a cycle
			row_c("G", 1'b1),               // upper case folds
			row_c("o", 1'b0),
			row_r(8'hFF, 1'b0, 1'b1, 16'h8000),
			row_c("g", 1'b1),
			row_c("e", 1'b0),               // found behind a sibling
			row_r(8'h00, 1'b0, 1'b1, 16'h0001),
			row_c("g", 1'b1),
			row_r("X", 1'b0, 1'b0, 16'h0000),
			row_c("z", 1'b0),               // dropped, word already decided
			row_r("5", 1'b1, 1'b0, 16'h0000),
			row_c("g", 1'b1),
			row_c("G", 1'b1),               // restart in mid-word
			row_c("o", 1'b0),
			row_r("q", 1'b0, 1'b0, 16'h0000),
			row_c("z", 1'b1),
			row_r("!", 1'b0, 1'b0, 16'h0000)  // loops until the walk cap
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// the table has no reset, so every entry is written before any walk
		for (int a = 0; a < TABLE_DEPTH; a++) begin
			send_item(write_item(a, 16'h0000));
		end
		foreach (directed[i]) begin
			send_item(directed[i].item, directed[i].typed, directed[i].res);
		end
		rand_start = n_items;
		while (n_items - rand_start < RAND_ITEMS) begin
			run_round();
		end
		quiet = 1'b0;
		feed_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		// catch a late result from a walk still running
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("fed %0d items, %0d words over %0d random tries", n_items, n_words, n_tables);
		$display("checked %0d results, %0d keyword hits, %0d mismatches",
			n_results, n_hits, n_errors);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/kptm_pkg.sv
hw/rtl/kptm_dp.sv
hw/rtl/kptm_ctrl.sv
hw/rtl/keyword_prefix_trie_matcher.sv
verif/tb_top.sv
